/* hdl/bis_pkg.sv */
// Package for the bilinear image scaler: payload structs, codes and defaults.
// No dependencies.
`default_nettype none
package bis_pkg;
    localparam int MAX_SRC_WIDTH_DEF  = 256;
    localparam int MAX_SRC_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF      = 16;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEP_X        = 2'd2;
    localparam logic [1:0] REG_STEP_Y        = 2'd3;

    localparam int CFG_WIDTH = 24;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  load_col;
        logic [7:0]  load_row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
        logic [11:0] dest_col;
        logic [11:0] dest_row;
    } item_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pixel_t;
endpackage
`default_nettype wire

/* hdl/bilinear_image_scaler_top.sv */
// Bilinear RGBA scaler top level: four-bank frame store and blend pipeline.
// Depends on bis_pkg.
//
// Usage: an item transfers at a clock edge with start high and busy low; busy
// is always low, so one item may transfer every cycle. A load item (cmd 0)
// writes one source pixel; a request item (cmd 1) yields one scaled pixel.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user must
// do them only while the pipeline is empty, and the block does not enforce it.
// Pipeline: S1 position multiply, S2 clamp and store access (loads write,
// requests read four banks split by row/column parity), S3 horizontal blend,
// S4 vertical blend into the output register. A request's result is on the
// result port with result_valid for one cycle, once it has passed S1, S2, S3
// and the output register. Throughput is one item per cycle. Reset clears
// pipeline valid bits and loads register defaults; the frame store is not
// cleared, and pixels must be loaded before being read.
// The receiver cannot stall; results are never held.
`default_nettype none
module bilinear_image_scaler_top #(
    parameter int MAX_SRC_WIDTH  = bis_pkg::MAX_SRC_WIDTH_DEF,
    parameter int MAX_SRC_HEIGHT = bis_pkg::MAX_SRC_HEIGHT_DEF,
    parameter int FRAC_BITS      = bis_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire bis_pkg::item_t                request,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [bis_pkg::CFG_WIDTH-1:0] cfg_data,
    output      logic                          result_valid,
    output      bis_pkg::pixel_t               result
);
    localparam int XW   = $clog2(MAX_SRC_WIDTH);
    localparam int YW   = $clog2(MAX_SRC_HEIGHT);
    localparam int BCOL = (MAX_SRC_WIDTH + 1) / 2;
    localparam int BROW = (MAX_SRC_HEIGHT + 1) / 2;
    localparam int BD   = BCOL * BROW;
    localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
    localparam int PW   = 36;
    localparam int IPW  = PW - FRAC_BITS;
    localparam int FW   = FRAC_BITS + 1;
    localparam int HW   = 8 + FRAC_BITS;
    localparam int VW   = HW + FW + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    logic [8:0]  source_width_reg, source_height_reg;
    logic [23:0] step_x_reg, step_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= 9'd256;
            source_height_reg <= 9'd256;
            step_x_reg        <= 24'd65536;
            step_y_reg        <= 24'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bis_pkg::REG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[8:0];
                bis_pkg::REG_SOURCE_HEIGHT: source_height_reg <= cfg_data[8:0];
                bis_pkg::REG_STEP_X:        step_x_reg        <= cfg_data;
                bis_pkg::REG_STEP_Y:        step_y_reg        <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // S1: position multiply
    logic          s1_valid_reg;
    bis_pkg::item_t s1_item_reg;
    logic [PW-1:0] s1_posx_reg, s1_posy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= request;
        s1_posx_reg <= PW'(request.dest_col) * PW'(step_x_reg);
        s1_posy_reg <= PW'(request.dest_row) * PW'(step_y_reg);
    end

    // S2: clamp, store access
    logic [31:0]    wsz, hsz;
    logic [XW-1:0]  last_x, x0, x1;
    logic [YW-1:0]  last_y, y0, y1;
    logic [IPW-1:0] ipx, ipy;
    logic           load_ok, is_load;

    always_comb
    begin
        wsz = (source_width_reg == 9'd0) ? 32'd1 :
              (32'(source_width_reg) > 32'(MAX_SRC_WIDTH)) ? 32'(MAX_SRC_WIDTH) :
              32'(source_width_reg);
        hsz = (source_height_reg == 9'd0) ? 32'd1 :
              (32'(source_height_reg) > 32'(MAX_SRC_HEIGHT)) ? 32'(MAX_SRC_HEIGHT) :
              32'(source_height_reg);
        last_x = XW'(wsz - 32'd1);
        last_y = YW'(hsz - 32'd1);
        ipx = s1_posx_reg[PW-1:FRAC_BITS];
        ipy = s1_posy_reg[PW-1:FRAC_BITS];
        x0 = (64'(ipx) > 64'(last_x)) ? last_x : XW'(ipx);
        y0 = (64'(ipy) > 64'(last_y)) ? last_y : YW'(ipy);
        x1 = (x0 == last_x) ? last_x : x0 + XW'(1);
        y1 = (y0 == last_y) ? last_y : y0 + YW'(1);
        is_load = s1_item_reg.cmd == bis_pkg::CMD_LOAD;
        load_ok = (32'(s1_item_reg.load_col) < 32'(MAX_SRC_WIDTH)) &&
                  (32'(s1_item_reg.load_row) < 32'(MAX_SRC_HEIGHT));
    end

    logic [31:0] wdata;
    assign wdata = {s1_item_reg.alpha_in, s1_item_reg.blue_in,
                    s1_item_reg.green_in, s1_item_reg.red_in};

    logic [31:0] bank_q [4];

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PX = 1'(b & 1);
        localparam logic PY = 1'((b >> 1) & 1);
        logic [31:0]   mem [BD];
        logic [31:0]   rc, rr, lc, lr;
        logic [AW-1:0] raddr, waddr;
        logic          we;

        always_comb
        begin
            rc = 32'((x0[0] == PX) ? x0 : x1);
            rr = 32'((y0[0] == PY) ? y0 : y1);
            lc = 32'(s1_item_reg.load_col);
            lr = 32'(s1_item_reg.load_row);
            raddr = AW'((rr >> 1) * BCOL + (rc >> 1));
            waddr = AW'((lr >> 1) * BCOL + (lc >> 1));
            we = s1_valid_reg && is_load && load_ok &&
                 (lc[0] == PX) && (lr[0] == PY);
        end

        always_ff @(posedge clk)
        begin
            if (we)
                mem[waddr] <= wdata;
            bank_q[b] <= mem[raddr];
        end
    end

    logic                s2_valid_reg;
    logic                s2_x0p_reg, s2_x1p_reg, s2_y0p_reg, s2_y1p_reg;
    logic [FRAC_BITS-1:0] s2_fx_reg, s2_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg && !is_load;
    end

    always_ff @(posedge clk)
    begin
        s2_x0p_reg <= x0[0];
        s2_x1p_reg <= x1[0];
        s2_y0p_reg <= y0[0];
        s2_y1p_reg <= y1[0];
        s2_fx_reg  <= s1_posx_reg[FRAC_BITS-1:0];
        s2_fy_reg  <= s1_posy_reg[FRAC_BITS-1:0];
    end

    // S3: horizontal blend
    logic [31:0] p00, p10, p01, p11;
    logic [FW-1:0] fx, fxc;
    assign p00 = bank_q[{s2_y0p_reg, s2_x0p_reg}];
    assign p10 = bank_q[{s2_y0p_reg, s2_x1p_reg}];
    assign p01 = bank_q[{s2_y1p_reg, s2_x0p_reg}];
    assign p11 = bank_q[{s2_y1p_reg, s2_x1p_reg}];
    assign fx  = FW'(s2_fx_reg);
    assign fxc = ONE - fx;

    logic          s3_valid_reg;
    logic [HW-1:0] s3_h0_reg [4];
    logic [HW-1:0] s3_h1_reg [4];
    logic [FRAC_BITS-1:0] s3_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_fy_reg <= s2_fy_reg;
        for (int c = 0; c < 4; c++)
        begin
            s3_h0_reg[c] <= HW'(HW'(p00[c*8 +: 8]) * HW'(fxc) + HW'(p10[c*8 +: 8]) * HW'(fx));
            s3_h1_reg[c] <= HW'(HW'(p01[c*8 +: 8]) * HW'(fxc) + HW'(p11[c*8 +: 8]) * HW'(fx));
        end
    end

    // S4: vertical blend, truncate
    logic [FW-1:0] fy, fyc;
    logic [VW-1:0] v [4];
    assign fy  = FW'(s3_fy_reg);
    assign fyc = ONE - fy;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            v[c] = VW'(s3_h0_reg[c]) * VW'(fyc) + VW'(s3_h1_reg[c]) * VW'(fy);
    end

    logic            result_valid_reg;
    bis_pkg::pixel_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        result_reg.red_out   <= v[0][2*FRAC_BITS +: 8];
        result_reg.green_out <= v[1][2*FRAC_BITS +: 8];
        result_reg.blue_out  <= v[2][2*FRAC_BITS +: 8];
        result_reg.alpha_out <= v[3][2*FRAC_BITS +: 8];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == bis_pkg::CMD_REQUEST) |-> ##4 result_valid)
        else $error("request transfer gave no result");
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == bis_pkg::CMD_LOAD) |-> ##4 !result_valid)
        else $error("load transfer gave a result");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(s3_valid_reg))
        else $error("result without a blend stage item");
`endif
endmodule
`default_nettype wire

/* tb/bilinear_image_scaler_top_test.sv */
// Testbench for bilinear_image_scaler_top: loads source frames, requests scaled pixels
// and checks every result against an in-bench bilinear predictor.
// Depends on bis_pkg and the bilinear_image_scaler_top RTL.
`default_nettype none
module bilinear_image_scaler_top_test;
    localparam int MW = bis_pkg::MAX_SRC_WIDTH_DEF;
    localparam int MH = bis_pkg::MAX_SRC_HEIGHT_DEF;
    localparam int FB = bis_pkg::FRAC_BITS_DEF;
    localparam longint unsigned UNITY = 64'd1 << FB;
    localparam int QUIET_LIMIT = 2000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    bis_pkg::item_t                request = '0;
    logic                          cfg_we = 1'b0;
    logic [1:0]                    cfg_index = bis_pkg::REG_SOURCE_WIDTH;
    logic [bis_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic                          result_valid;
    bis_pkg::pixel_t               result;

    logic [8:0]      src_cols = 9'd256;
    logic [8:0]      src_rows = 9'd256;
    logic [23:0]     step_col = 24'd65536;
    logic [23:0]     step_row = 24'd65536;
    logic [31:0]     frame_mem [MW*MH];
    bit              loaded [MW*MH];
    bis_pkg::pixel_t pending_pixels [$];
    int              errors = 0;
    int              quiet_cycles = 0;
    bit              gaps_on = 1'b1;

    bilinear_image_scaler_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_size(input logic [8:0] v, input int maxv);
        if (v == 0)
            return 1;
        return (v > maxv) ? maxv : int'(v);
    endfunction

    function automatic void locate_axis(input logic [11:0] coord, input logic [23:0] step,
                                        input int size, output int i0, output int i1,
                                        output longint unsigned frac);
        longint unsigned pos;
        longint unsigned ip;
        int              last;
        pos  = {52'd0, coord} * {40'd0, step};
        ip   = pos >> FB;
        last = size - 1;
        i0   = (ip > longint'(last)) ? last : int'(ip);
        i1   = (i0 + 1 > last) ? last : i0 + 1;
        frac = pos & (UNITY - 1);
    endfunction

    function automatic bis_pkg::pixel_t blend_pixel(input bis_pkg::item_t it);
        int              x0, x1, y0, y1;
        longint unsigned fx, fy, a, b, d, e, h0, h1, v;
        logic [7:0]      ch [4];
        bis_pkg::pixel_t px;
        locate_axis(it.dest_col, step_col, eff_size(src_cols, MW), x0, x1, fx);
        locate_axis(it.dest_row, step_row, eff_size(src_rows, MH), y0, y1, fy);
        for (int c = 0; c < 4; c++)
        begin
            a = frame_mem[y0*MW + x0][c*8 +: 8];
            b = frame_mem[y0*MW + x1][c*8 +: 8];
            d = frame_mem[y1*MW + x0][c*8 +: 8];
            e = frame_mem[y1*MW + x1][c*8 +: 8];
            h0 = a * (UNITY - fx) + b * fx;
            h1 = d * (UNITY - fx) + e * fx;
            v  = (h0 * (UNITY - fy) + h1 * fy) >> (2 * FB);
            ch[c] = v[7:0];
        end
        px.red_out   = ch[0];
        px.green_out = ch[1];
        px.blue_out  = ch[2];
        px.alpha_out = ch[3];
        return px;
    endfunction

    task automatic send_item(input bis_pkg::item_t it);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= it;
        do @(posedge clk); while (busy);
        if (it.cmd == bis_pkg::CMD_LOAD)
        begin
            frame_mem[it.load_row*MW + it.load_col] =
                {it.alpha_in, it.blue_in, it.green_in, it.red_in};
            loaded[it.load_row*MW + it.load_col] = 1'b1;
        end
        else
            pending_pixels.push_back(blend_pixel(it));
    endtask

    task automatic load_pixel(input int col, input int row, input logic [31:0] rgba);
        bis_pkg::item_t it;
        it = bis_pkg::item_t'({$urandom, $urandom, $urandom});
        it.cmd      = bis_pkg::CMD_LOAD;
        it.load_col = col[7:0];
        it.load_row = row[7:0];
        {it.alpha_in, it.blue_in, it.green_in, it.red_in} = rgba;
        send_item(it);
    endtask

    // Loads any neighbor not yet written so no unwritten entry is ever read.
    task automatic request_pixel(input logic [11:0] col, input logic [11:0] row);
        bis_pkg::item_t  it;
        int              x0, x1, y0, y1;
        longint unsigned fx, fy;
        locate_axis(col, step_col, eff_size(src_cols, MW), x0, x1, fx);
        locate_axis(row, step_row, eff_size(src_rows, MH), y0, y1, fy);
        if (!loaded[y0*MW + x0]) load_pixel(x0, y0, $urandom);
        if (!loaded[y0*MW + x1]) load_pixel(x1, y0, $urandom);
        if (!loaded[y1*MW + x0]) load_pixel(x0, y1, $urandom);
        if (!loaded[y1*MW + x1]) load_pixel(x1, y1, $urandom);
        it = bis_pkg::item_t'({$urandom, $urandom, $urandom});
        it.cmd      = bis_pkg::CMD_REQUEST;
        it.dest_col = col;
        it.dest_row = row;
        send_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [8:0] w, input logic [8:0] h,
                              input logic [23:0] sx, input logic [23:0] sy);
        drain();
        repeat (6) @(posedge clk);
        write_reg(bis_pkg::REG_SOURCE_WIDTH, {15'd0, w});
        write_reg(bis_pkg::REG_SOURCE_HEIGHT, {15'd0, h});
        write_reg(bis_pkg::REG_STEP_X, sx);
        write_reg(bis_pkg::REG_STEP_Y, sy);
        cfg_we   <= 1'b0;
        src_cols = w;
        src_rows = h;
        step_col = sx;
        step_row = sy;
    endtask

    function automatic logic [8:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd256;
            2: return 9'($urandom_range(257, 511));
            3: return 9'd1;
            default: return 9'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [23:0] pick_step();
        case ($urandom_range(0, 7))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 3 * 65536));
        endcase
    endfunction

    task automatic test_directed();
        set_config(9'd2, 9'd2, 24'h008000, 24'h008000);
        load_pixel(0, 0, 32'h00000000);
        load_pixel(1, 0, 32'hFFFFFFFF);
        load_pixel(0, 1, 32'hFFFFFFFF);
        load_pixel(1, 1, 32'h80FF0001);
        request_pixel(12'd0, 12'd0);
        request_pixel(12'd1, 12'd1);
        request_pixel(12'd1, 12'd0);
        request_pixel(12'd4095, 12'd4095);
        set_config(9'd0, 9'd0, 24'hFFFFFF, 24'd0);
        request_pixel(12'd4095, 12'd0);
        set_config(9'd511, 9'd300, 24'hFFFFFF, 24'hFFFFFF);
        load_pixel(255, 255, 32'hFFFFFFFF);
        load_pixel(255, 0, 32'h12345678);
        request_pixel(12'd4095, 12'd4095);
        request_pixel(12'd0, 12'd1);
        set_config(9'd256, 9'd256, 24'd0, 24'd0);
        request_pixel(12'd4095, 12'd4095);
    endtask

    task automatic run_phase(input int n_items, input bit mid_drain);
        int w, h;
        set_config(pick_size(), pick_size(), pick_step(), pick_step());
        w = eff_size(src_cols, MW);
        h = eff_size(src_rows, MH);
        for (int i = 0; i < n_items; i++)
        begin
            if (mid_drain && i == n_items / 2)
                drain();
            if ($urandom_range(0, 9) < 3)
            begin
                if ($urandom_range(0, 3) == 0)
                    load_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                else
                    load_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
            end
            else if ($urandom_range(0, 1) == 0)
                request_pixel(12'($urandom_range(0, 63)), 12'($urandom_range(0, 63)));
            else
                request_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 9; p++)
            run_phase(140, p == 3);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        run_phase(200, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        bis_pkg::pixel_t want;
        if (rst_n && result_valid)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red_out", want.red_out, result.red_out);
                check_field("green_out", want.green_out, result.green_out);
                check_field("blue_out", want.blue_out, result.blue_out);
                check_field("alpha_out", want.alpha_out, result.alpha_out);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_settings();
        test_back_to_back();
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/bis_pkg.sv
hdl/bilinear_image_scaler_top.sv
tb/bilinear_image_scaler_top_test.sv
